// File: hw/rtl/spatial_hash_neighbor_search_macros.svh
// Assertion macros for the spatial hash neighbor search block.
`ifndef SPATIAL_HASH_NEIGHBOR_SEARCH_MACROS_SVH
`define SPATIAL_HASH_NEIGHBOR_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define SHNS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shns: assertion failed");
// Check cons in the cycle after ante.
`define SHNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shns: assertion failed");
`else
`define SHNS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SHNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/shns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shns_pkg;

    localparam int unsigned DEF_MAX_PARTICLES = 1024;
    localparam int unsigned DEF_TABLE_BUCKETS = 1024;
    localparam int unsigned DEF_BUCKET_DEPTH  = 8;
    localparam int unsigned DEF_MAX_NEIGHBORS = 32;
    localparam int unsigned DEF_HASH_PRIME_X  = 73856093;
    localparam int unsigned DEF_HASH_PRIME_Y  = 19349663;

    localparam int FUNC_W     = 2;
    localparam int POS_W      = 24;
    localparam int IDX_W      = 10;
    localparam int ST_W       = 3;
    localparam int CELL_W     = 13;
    localparam int SCALE_W    = 16;
    localparam int KRS_W      = 48;
    localparam int CELL_FRAC  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL     = 2'd3;

    localparam logic [SCALE_W-1:0] RST_CELL_SCALE = 16'd256;
    localparam logic [CELL_W-1:0]  RST_GRID_ROWS  = 13'd64;
    localparam logic [CELL_W-1:0]  RST_GRID_COLS  = 13'd64;
    localparam logic [KRS_W-1:0]   RST_KERNEL     = 48'd16777216;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_INSERT = 2'd1,
        FN_QUERY  = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_OUTSIDE     = 3'd1,
        ST_BUCKET_FULL = 3'd2,
        ST_STORE_FULL  = 3'd3,
        ST_BAD_INDEX   = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    accept;
        logic    clr_start;
        logic    clr_step;
        logic    ins_store;
        logic    pos_rd_q;
        logic    pos_rd_m;
        logic    cell_calc;
        logic    win_calc;
        logic    hash_mul;
        logic    hash_sum;
        logic    hash_step;
        logic    scan_init;
        logic    fill_rd;
        logic    memb_wr;
        logic    memb_rd;
        logic    adv_slot;
        logic    adv_j;
        logic    adv_i;
        logic    dist_mul;
        logic    hit_take;
        logic    hit_over;
        logic    push_fin;
        status_t fin_status;
    } shns_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic  in_valid;
        func_t in_func;
        func_t func;
        logic  store_full;
        logic  bad_q;
        logic  in_grid;
        logic  sweep_done;
        logic  hash_done;
        logic  bucket_full;
        logic  slot_end;
        logic  j_end;
        logic  i_end;
        logic  self_hit;
        logic  near;
        logic  n_full;
        logic  pend_valid;
        logic  can_push;
    } shns_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/shns_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface shns_item_if import shns_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [IDX_W-1:0]         query_index;

    modport source (output valid, func, pos_x, pos_y, query_index, input ready);
    modport sink   (input valid, func, pos_x, pos_y, query_index, output ready);
endinterface

interface shns_result_if import shns_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  particle_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic              neighbor_valid;
    logic              list_overflow;
    logic              last;

    modport source (output valid, status, particle_index, neighbor_index, neighbor_valid,
                    list_overflow, last, input ready);
    modport sink   (input valid, status, particle_index, neighbor_index, neighbor_valid,
                    list_overflow, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/shns_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module shns_ctrl import shns_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  shns_stat_t stat,
    output shns_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_CLR  = 15'b000000000000010,
        S_CELL = 15'b000000000000100,
        S_WIN  = 15'b000000000001000,
        S_HMUL = 15'b000000000010000,
        S_HSUM = 15'b000000000100000,
        S_HRED = 15'b000000001000000,
        S_FILL = 15'b000000010000000,
        S_INSW = 15'b000000100000000,
        S_SCAN = 15'b000001000000000,
        S_SLOT = 15'b000010000000000,
        S_POS  = 15'b000100000000000,
        S_MUL  = 15'b001000000000000,
        S_CMP  = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } state_t;

    state_t  state_reg, state_next;
    logic    clr_op_reg, clr_op_next;
    status_t code_reg, code_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        clr_op_next    = clr_op_reg;
        code_next      = code_reg;
        cmd.fin_status = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.accept = 1'b1;
                    code_next  = ST_OK;
                    case (stat.in_func)
                        FN_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            clr_op_next   = 1'b1;
                            state_next    = S_CLR;
                        end
                        FN_INSERT:
                        begin
                            if (stat.store_full)
                            begin
                                code_next  = ST_STORE_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CELL;
                            end
                        end
                        FN_QUERY:
                        begin
                            if (stat.bad_q)
                            begin
                                code_next  = ST_BAD_INDEX;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.pos_rd_q = 1'b1;
                                state_next   = S_CELL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.sweep_done)
                begin
                    clr_op_next = 1'b0;
                    state_next  = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_CELL:
            begin
                cmd.cell_calc = 1'b1;
                cmd.ins_store = (stat.func == FN_INSERT);
                state_next    = S_WIN;
            end
            S_WIN:
            begin
                cmd.win_calc = 1'b1;
                state_next   = S_HMUL;
            end
            S_HMUL:
            begin
                if (!stat.in_grid)
                begin
                    code_next  = ST_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.hash_mul = 1'b1;
                    state_next   = S_HSUM;
                end
            end
            S_HSUM:
            begin
                cmd.hash_sum = 1'b1;
                state_next   = S_HRED;
            end
            S_HRED:
            begin
                if (stat.hash_done)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = (stat.func == FN_INSERT) ? S_FILL : S_SCAN;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_FILL:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_INSW;
            end
            S_INSW:
            begin
                if (stat.bucket_full)
                begin
                    code_next = ST_BUCKET_FULL;
                end
                else
                begin
                    cmd.memb_wr = 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_SLOT;
            end
            S_SLOT:
            begin
                if (stat.slot_end)
                begin
                    if (!stat.j_end)
                    begin
                        cmd.adv_j  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else if (!stat.i_end)
                    begin
                        cmd.adv_i  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.memb_rd = 1'b1;
                    state_next  = S_POS;
                end
            end
            S_POS:
            begin
                if (stat.self_hit)
                begin
                    cmd.adv_slot = 1'b1;
                    state_next   = S_SLOT;
                end
                else
                begin
                    cmd.pos_rd_m = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.dist_mul = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                if (!stat.near)
                begin
                    cmd.adv_slot = 1'b1;
                    state_next   = S_SLOT;
                end
                else if (stat.n_full)
                begin
                    cmd.hit_over = 1'b1;
                    cmd.adv_slot = 1'b1;
                    state_next   = S_SLOT;
                end
                else if (!stat.pend_valid || stat.can_push)
                begin
                    cmd.hit_take = 1'b1;
                    cmd.adv_slot = 1'b1;
                    state_next   = S_SLOT;
                end
            end
            S_DONE:
            begin
                if (stat.can_push)
                begin
                    cmd.push_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_op_reg <= 1'b0;
            code_reg   <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_op_reg <= clr_op_next;
            code_reg   <= code_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/shns_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module shns_dp import shns_pkg::*; #(
    parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int unsigned TABLE_BUCKETS = DEF_TABLE_BUCKETS,
    parameter int unsigned BUCKET_DEPTH  = DEF_BUCKET_DEPTH,
    parameter int unsigned MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
    parameter int unsigned HASH_PRIME_X  = DEF_HASH_PRIME_X,
    parameter int unsigned HASH_PRIME_Y  = DEF_HASH_PRIME_Y
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    item_valid,
    input  logic [FUNC_W-1:0]       item_func,
    input  logic signed [POS_W-1:0] item_pos_x,
    input  logic signed [POS_W-1:0] item_pos_y,
    input  logic [IDX_W-1:0]        item_query_index,
    input  logic                    result_ready,
    output logic                    result_valid,
    output logic [ST_W-1:0]         result_status,
    output logic [IDX_W-1:0]        result_particle_index,
    output logic [IDX_W-1:0]        result_neighbor_index,
    output logic                    result_neighbor_valid,
    output logic                    result_list_overflow,
    output logic                    result_last,
    input  shns_cmd_t               cmd,
    output shns_stat_t              stat
);

    localparam int PIDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int HB_W   = $clog2(TABLE_BUCKETS);
    localparam int MA_W   = $clog2(TABLE_BUCKETS * BUCKET_DEPTH);
    localparam int SL_W   = $clog2(BUCKET_DEPTH + 1);
    localparam int NB_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int HP_W   = HB_W + CELL_W;
    localparam int HS_W   = HP_W + 1;
    localparam int HC_W   = 2;
    localparam int HM_W   = 2 * HS_W;
    localparam int PROD_W = POS_W + SCALE_W;
    localparam int CQ_W   = PROD_W - CELL_FRAC;
    localparam int DX_W   = POS_W + 1;
    localparam int SQ_W   = 2 * DX_W;
    localparam int D2_W   = SQ_W + 1;

    localparam logic [HB_W-1:0] PXM    = HB_W'(HASH_PRIME_X % TABLE_BUCKETS);
    localparam logic [HB_W-1:0] PYM    = HB_W'(HASH_PRIME_Y % TABLE_BUCKETS);
    localparam logic [HB_W:0]   T_C    = (HB_W + 1)'(TABLE_BUCKETS);
    localparam logic [HB_W-1:0] T_LAST = HB_W'(TABLE_BUCKETS - 1);
    localparam logic [HS_W-1:0] T_S    = HS_W'(TABLE_BUCKETS);
    localparam logic [HS_W-1:0] RECIP  = HS_W'((64'd1 << HS_W) / 64'(TABLE_BUCKETS));

    function automatic logic [HB_W-1:0] addmod(input logic [HB_W-1:0] a,
                                               input logic [HB_W-1:0] b);
        logic [HB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= T_C) ? HB_W'(s - T_C) : HB_W'(s);
    endfunction

    // configuration
    logic [SCALE_W-1:0] scale_reg;
    logic [CELL_W-1:0]  rows_reg, cols_reg;
    logic [KRS_W-1:0]   kernel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= RST_CELL_SCALE;
            rows_reg   <= RST_GRID_ROWS;
            cols_reg   <= RST_GRID_COLS;
            kernel_reg <= RST_KERNEL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CELL_SCALE: scale_reg  <= cfg_wdata[SCALE_W-1:0];
                CFG_GRID_ROWS:  rows_reg   <= cfg_wdata[CELL_W-1:0];
                CFG_GRID_COLS:  cols_reg   <= cfg_wdata[CELL_W-1:0];
                CFG_KERNEL:     kernel_reg <= cfg_wdata[KRS_W-1:0];
                default: ;
            endcase
        end
    end

    // latched word
    logic [FUNC_W-1:0]       func_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [IDX_W-1:0]        q_reg;
    logic [PIDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]        count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= item_func;
            px_reg   <= item_pos_x;
            py_reg   <= item_pos_y;
            q_reg    <= item_query_index;
            idx_reg  <= PIDX_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            count_reg <= '0;
        end
        else if (cmd.ins_store)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // position store
    logic signed [POS_W-1:0] mem_x [MAX_PARTICLES];
    logic signed [POS_W-1:0] mem_y [MAX_PARTICLES];
    logic signed [POS_W-1:0] rdx_reg, rdy_reg;
    logic [PIDX_W-1:0]       memb_rd_reg;
    logic [PIDX_W-1:0]       pos_addr;

    assign pos_addr = cmd.pos_rd_q ? PIDX_W'(item_query_index) : memb_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ins_store)
        begin
            mem_x[idx_reg] <= px_reg;
            mem_y[idx_reg] <= py_reg;
        end
        if (cmd.pos_rd_q || cmd.pos_rd_m)
        begin
            rdx_reg <= mem_x[pos_addr];
            rdy_reg <= mem_y[pos_addr];
        end
    end

    // cell of a position: magnitude times scale, truncate, keep the sign flag
    logic signed [POS_W-1:0] src_x, src_y;
    logic [POS_W-1:0]        mag_x, mag_y;
    logic [PROD_W-1:0]       prod_x, prod_y;
    logic signed [POS_W-1:0] qx_reg, qy_reg;
    logic                    negx_reg, negy_reg;
    logic [CQ_W-1:0]         cqx_reg, cqy_reg;

    assign src_x  = (func_reg == FN_INSERT) ? px_reg : rdx_reg;
    assign src_y  = (func_reg == FN_INSERT) ? py_reg : rdy_reg;
    assign mag_x  = src_x[POS_W-1] ? POS_W'(-src_x) : POS_W'(src_x);
    assign mag_y  = src_y[POS_W-1] ? POS_W'(-src_y) : POS_W'(src_y);
    assign prod_x = PROD_W'(mag_x) * PROD_W'(scale_reg);
    assign prod_y = PROD_W'(mag_y) * PROD_W'(scale_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cell_calc)
        begin
            qx_reg   <= src_x;
            qy_reg   <= src_y;
            negx_reg <= src_x[POS_W-1];
            negy_reg <= src_y[POS_W-1];
            cqx_reg  <= prod_x[PROD_W-1:CELL_FRAC];
            cqy_reg  <= prod_y[PROD_W-1:CELL_FRAC];
        end
    end

    // grid check and clamped window
    logic              in_x, in_y, in_grid_reg;
    logic [CELL_W-1:0] cx, cy;
    logic [CELL_W-1:0] cx_reg, cy_reg, i0_reg, i1_reg, j0_reg, j1_reg;

    assign in_x = (!negx_reg || cqx_reg == '0) && (cqx_reg < CQ_W'(rows_reg));
    assign in_y = (!negy_reg || cqy_reg == '0) && (cqy_reg < CQ_W'(cols_reg));
    assign cx   = cqx_reg[CELL_W-1:0];
    assign cy   = cqy_reg[CELL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.win_calc)
        begin
            in_grid_reg <= in_x && in_y;
            cx_reg      <= cx;
            cy_reg      <= cy;
            i0_reg      <= (cx != '0) ? cx - 1'b1 : cx;
            j0_reg      <= (cy != '0) ? cy - 1'b1 : cy;
            i1_reg      <= ((CELL_W + 1)'(cx) + 1'b1 < (CELL_W + 1)'(rows_reg)) ? cx + 1'b1 : cx;
            j1_reg      <= ((CELL_W + 1)'(cy) + 1'b1 < (CELL_W + 1)'(cols_reg)) ? cy + 1'b1 : cy;
        end
    end

    // hash: products, sum, then reduction by reciprocal multiply over three steps
    logic [CELL_W-1:0] base_i, base_j;
    logic [HP_W-1:0]   hx_reg, hy_reg;
    logic [HS_W-1:0]   hsum_reg, quo_reg;
    logic [HM_W-1:0]   hq_prod;
    logic [HS_W-1:0]   hr_diff;
    logic [HB_W:0]     rw_reg;
    logic [HB_W-1:0]   rem_reg;
    logic [HC_W-1:0]   hcnt_reg;

    assign base_i  = (func_reg == FN_QUERY) ? i0_reg : cx_reg;
    assign base_j  = (func_reg == FN_QUERY) ? j0_reg : cy_reg;
    assign hq_prod = HM_W'(hsum_reg) * HM_W'(RECIP);
    assign hr_diff = hsum_reg - quo_reg * T_S;

    always_ff @(posedge clk)
    begin
        if (cmd.hash_mul)
        begin
            hx_reg <= HP_W'(PXM) * HP_W'(base_i);
            hy_reg <= HP_W'(PYM) * HP_W'(base_j);
        end
        if (cmd.hash_sum)
        begin
            hsum_reg <= HS_W'(hx_reg) + HS_W'(hy_reg);
            hcnt_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            // quotient estimate is low by at most one: one subtract finishes
            case (hcnt_reg)
                HC_W'(0): quo_reg <= hq_prod[HM_W-1:HS_W];
                HC_W'(1): rw_reg  <= hr_diff[HB_W:0];
                default:  rem_reg <= (rw_reg >= T_C) ? HB_W'(rw_reg - T_C) : HB_W'(rw_reg);
            endcase
            hcnt_reg <= hcnt_reg + 1'b1;
        end
    end

    // scan position over the window
    logic [HB_W-1:0]   hash_reg, row_reg;
    logic [CELL_W-1:0] i_reg, j_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            hash_reg <= rem_reg;
            row_reg  <= rem_reg;
            i_reg    <= i0_reg;
            j_reg    <= j0_reg;
        end
        else if (cmd.adv_j)
        begin
            j_reg    <= j_reg + 1'b1;
            hash_reg <= addmod(hash_reg, PYM);
        end
        else if (cmd.adv_i)
        begin
            i_reg    <= i_reg + 1'b1;
            j_reg    <= j0_reg;
            row_reg  <= addmod(row_reg, PXM);
            hash_reg <= addmod(row_reg, PXM);
        end
    end

    // bucket fill counts, swept to zero after reset and on clear
    logic [SL_W-1:0] mem_fill [TABLE_BUCKETS];
    logic [SL_W-1:0] fill_rd_reg;
    logic [HB_W-1:0] clr_cnt_reg;
    logic [SL_W-1:0] slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem_fill[clr_cnt_reg] <= '0;
        end
        else if (cmd.memb_wr)
        begin
            mem_fill[hash_reg] <= fill_rd_reg + 1'b1;
        end
        if (cmd.fill_rd)
        begin
            fill_rd_reg <= mem_fill[hash_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_rd)
        begin
            slot_reg <= '0;
        end
        else if (cmd.adv_slot)
        begin
            slot_reg <= slot_reg + 1'b1;
        end
    end

    // bucket members
    logic [PIDX_W-1:0] mem_memb [TABLE_BUCKETS * BUCKET_DEPTH];
    logic [MA_W-1:0]   bkt_base;

    assign bkt_base = MA_W'(hash_reg) * MA_W'(BUCKET_DEPTH);

    always_ff @(posedge clk)
    begin
        if (cmd.memb_wr)
        begin
            mem_memb[bkt_base + MA_W'(fill_rd_reg)] <= idx_reg;
        end
        if (cmd.memb_rd)
        begin
            memb_rd_reg <= mem_memb[bkt_base + MA_W'(slot_reg)];
        end
    end

    // squared distance
    logic signed [DX_W-1:0] dx, dy;
    logic signed [SQ_W-1:0] sq_x, sq_y;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [D2_W-1:0]        d2;

    assign dx   = {qx_reg[POS_W-1], qx_reg} - {rdx_reg[POS_W-1], rdx_reg};
    assign dy   = {qy_reg[POS_W-1], qy_reg} - {rdy_reg[POS_W-1], rdy_reg};
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;
    assign d2   = D2_W'(sqx_reg) + D2_W'(sqy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.dist_mul)
        begin
            sqx_reg <= SQ_W'(sq_x);
            sqy_reg <= SQ_W'(sq_y);
        end
    end

    // one hit held back so the final one can carry last
    logic              pend_valid_reg, over_reg;
    logic [PIDX_W-1:0] pend_reg;
    logic [NB_W-1:0]   n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            over_reg       <= 1'b0;
            n_reg          <= '0;
        end
        else if (cmd.accept)
        begin
            pend_valid_reg <= 1'b0;
            over_reg       <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            if (cmd.hit_take)
            begin
                pend_valid_reg <= 1'b1;
                n_reg          <= n_reg + 1'b1;
            end
            else if (cmd.push_fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.hit_over)
            begin
                over_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hit_take)
        begin
            pend_reg <= memb_rd_reg;
        end
    end

    // output register
    logic             out_valid_reg, can_push, push;
    logic [ST_W-1:0]  out_st_reg;
    logic [IDX_W-1:0] out_pidx_reg, out_nidx_reg, fin_pidx;
    logic             out_nv_reg, out_ov_reg, out_last_reg;

    assign can_push = !out_valid_reg || result_ready;
    assign push     = (cmd.hit_take && pend_valid_reg) || cmd.push_fin;

    always_comb
    begin
        if (func_reg == FN_QUERY)
        begin
            fin_pidx = q_reg;
        end
        else if (func_reg == FN_INSERT && cmd.fin_status != ST_STORE_FULL)
        begin
            fin_pidx = IDX_W'(idx_reg);
        end
        else
        begin
            fin_pidx = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_st_reg   <= ST_OK;
                out_pidx_reg <= q_reg;
                out_nidx_reg <= IDX_W'(pend_reg);
                out_nv_reg   <= 1'b1;
                out_ov_reg   <= cmd.push_fin && over_reg;
                out_last_reg <= cmd.push_fin;
            end
            else
            begin
                out_st_reg   <= cmd.fin_status;
                out_pidx_reg <= fin_pidx;
                out_nidx_reg <= '0;
                out_nv_reg   <= 1'b0;
                out_ov_reg   <= 1'b0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign result_valid          = out_valid_reg;
    assign result_status         = out_st_reg;
    assign result_particle_index = out_pidx_reg;
    assign result_neighbor_index = out_nidx_reg;
    assign result_neighbor_valid = out_nv_reg;
    assign result_list_overflow  = out_ov_reg;
    assign result_last           = out_last_reg;

    // status to controller
    always_comb
    begin
        stat             = '0;
        stat.in_valid    = item_valid;
        stat.in_func     = func_t'(item_func);
        stat.func        = func_t'(func_reg);
        stat.store_full  = count_reg >= CNT_W'(MAX_PARTICLES);
        stat.bad_q       = 32'(item_query_index) >= 32'(count_reg);
        stat.in_grid     = in_grid_reg;
        stat.sweep_done  = clr_cnt_reg == T_LAST;
        stat.hash_done   = hcnt_reg == HC_W'(3);
        stat.bucket_full = fill_rd_reg >= SL_W'(BUCKET_DEPTH);
        stat.slot_end    = slot_reg >= fill_rd_reg;
        stat.j_end       = j_reg == j1_reg;
        stat.i_end       = i_reg == i1_reg;
        stat.self_hit    = memb_rd_reg == PIDX_W'(q_reg);
        stat.near        = d2 <= D2_W'(kernel_reg);
        stat.n_full      = n_reg >= NB_W'(MAX_NEIGHBORS);
        stat.pend_valid  = pend_valid_reg;
        stat.can_push    = can_push;
    end

endmodule

`default_nettype wire

// File: hw/rtl/spatial_hash_neighbor_search.sv
// Spatial hash neighbor search over a 2D grid of cells.
// Channels: item (valid/ready) carries one word per operation: clear,
// insert of a position, or query of a stored index. result (valid/ready)
// returns the words an item causes; the final one has last set. Config is
// a plain write port (cfg_wr_en, cfg_index, cfg_wdata), to be written
// by the user only while idle; the block itself does not enforce this.
// The hash is reduced modulo the table size by a reciprocal multiply.
// One item is in flight at a time; the next word can be taken in the
// cycle after the final result is registered. After reset the fill table
// is swept to zero before the first item is taken.
// A stalled receiver holds the result word in the output register; a query
// waits when its next hit finds that register still full.
`timescale 1ns / 1ps
`default_nettype none
`include "spatial_hash_neighbor_search_macros.svh"

module spatial_hash_neighbor_search import shns_pkg::*; #(
    parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int unsigned TABLE_BUCKETS = DEF_TABLE_BUCKETS,
    parameter int unsigned BUCKET_DEPTH  = DEF_BUCKET_DEPTH,
    parameter int unsigned MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
    parameter int unsigned HASH_PRIME_X  = DEF_HASH_PRIME_X,
    parameter int unsigned HASH_PRIME_Y  = DEF_HASH_PRIME_Y
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    shns_item_if.sink             item,
    shns_result_if.source         result
);

    shns_cmd_t  cmd;
    shns_stat_t stat;

    // the controller alone decides when a word is taken
    assign item.ready = cmd.in_ready;

    shns_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .cmd  (cmd)
    );

    shns_dp #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .TABLE_BUCKETS(TABLE_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .MAX_NEIGHBORS(MAX_NEIGHBORS),
        .HASH_PRIME_X (HASH_PRIME_X),
        .HASH_PRIME_Y (HASH_PRIME_Y)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .item_valid           (item.valid),
        .item_func            (item.func),
        .item_pos_x           (item.pos_x),
        .item_pos_y           (item.pos_y),
        .item_query_index     (item.query_index),
        .result_ready         (result.ready),
        .result_valid         (result.valid),
        .result_status        (result.status),
        .result_particle_index(result.particle_index),
        .result_neighbor_index(result.neighbor_index),
        .result_neighbor_valid(result.neighbor_valid),
        .result_list_overflow (result.list_overflow),
        .result_last          (result.last),
        .cmd                  (cmd),
        .stat                 (stat)
    );

    // a real operation closes the input until its results are out
    `SHNS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item.valid && item.ready && item.func != FN_NOP, !item.ready)
    // a found neighbor is always reported with an ok status
    `SHNS_ASSERT_NOW(a_hit_ok, clk, rst_n, result.valid && result.neighbor_valid, result.status == ST_OK)
    // overflow only on the final word of a query that found neighbors
    `SHNS_ASSERT_NOW(a_ovf_last, clk, rst_n, result.valid && result.list_overflow, result.last && result.neighbor_valid)

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import shns_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct {
        func_t                   func;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [IDX_W-1:0]        q;
    } item_word_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] particle_index;
        logic [IDX_W-1:0] neighbor_index;
        logic             neighbor_valid;
        logic             list_overflow;
        logic             last;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    shns_item_if   item ();
    shns_result_if result ();

    spatial_hash_neighbor_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item.sink),
        .result    (result.source)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the block: registers, particle store and hash table.
    logic [SCALE_W-1:0] sh_scale;
    logic [CELL_W-1:0]  sh_rows;
    logic [CELL_W-1:0]  sh_cols;
    logic [KRS_W-1:0]   sh_range_sq;
    int                 sh_x [DEF_MAX_PARTICLES];
    int                 sh_y [DEF_MAX_PARTICLES];
    int                 sh_count;
    int                 sh_fill [DEF_TABLE_BUCKETS];
    int                 sh_members [DEF_TABLE_BUCKETS * DEF_BUCKET_DEPTH];

    item_word_t   pending_items [$];
    result_word_t expected_words [$];

    int  mismatches  = 0;
    int  gen_count   = 0;   // particle count as seen by the stimulus generator
    bit  quiet       = 1'b0;
    int  send_idle   = 0;
    int  recv_stall  = 0;
    int  long_hold   = 0;
    int  quiet_cycles = 0;
    bit  took_item;

    // Cell coordinate: magnitude times scale in UQ0.20, truncated toward zero.
    function automatic longint cell_coord(input int p);
        longint mag;
        longint q;
        mag = (p < 0) ? -longint'(p) : longint'(p);
        q   = (mag * longint'(sh_scale)) >>> CELL_FRAC;
        return (p < 0) ? -q : q;
    endfunction

    function automatic bit cell_in_grid(input longint cx, input longint cy);
        return cx >= 0 && cx < longint'(sh_rows) && cy >= 0 && cy < longint'(sh_cols);
    endfunction

    function automatic int bucket_of(input longint cx, input longint cy);
        longint unsigned h;
        h = longint'(DEF_HASH_PRIME_X) * cx + longint'(DEF_HASH_PRIME_Y) * cy;
        return int'(h % DEF_TABLE_BUCKETS);
    endfunction

    function automatic result_word_t single_word(input status_t st, input int pidx);
        result_word_t r;
        r = '0;
        r.status         = st;
        r.particle_index = pidx[IDX_W-1:0];
        r.last           = 1'b1;
        return r;
    endfunction

    // Append one word to the expected results.
    function automatic void expect_word(input result_word_t r);
        expected_words.insert(expected_words.size(), r);
    endfunction

    // Work out the result words of one accepted item and advance the shadow state.
    task automatic predict_item(input item_word_t w);
        int           idx;
        int           b;
        int           q;
        longint       cx;
        longint       cy;
        longint       i0;
        longint       i1;
        longint       j0;
        longint       j1;
        longint       dx;
        longint       dy;
        longint unsigned d2;
        int           m;
        bit           over;
        result_word_t hits [$];
        result_word_t r;
        over = 1'b0;
        case (w.func)
            FN_CLEAR:
            begin
                sh_count = 0;
                foreach (sh_fill[k]) sh_fill[k] = 0;
                expect_word(single_word(ST_OK, 0));
            end
            FN_INSERT:
            begin
                if (sh_count >= DEF_MAX_PARTICLES)
                    expect_word(single_word(ST_STORE_FULL, 0));
                else
                begin
                    idx = sh_count;
                    sh_x[idx] = int'(w.x);
                    sh_y[idx] = int'(w.y);
                    sh_count++;
                    cx = cell_coord(sh_x[idx]);
                    cy = cell_coord(sh_y[idx]);
                    if (!cell_in_grid(cx, cy))
                        expect_word(single_word(ST_OUTSIDE, idx));
                    else
                    begin
                        b = bucket_of(cx, cy);
                        if (sh_fill[b] >= DEF_BUCKET_DEPTH)
                            expect_word(single_word(ST_BUCKET_FULL, idx));
                        else
                        begin
                            sh_members[b * DEF_BUCKET_DEPTH + sh_fill[b]] = idx;
                            sh_fill[b]++;
                            expect_word(single_word(ST_OK, idx));
                        end
                    end
                end
            end
            FN_QUERY:
            begin
                q = int'(w.q);
                if (q >= sh_count)
                    expect_word(single_word(ST_BAD_INDEX, q));
                else
                begin
                    cx = cell_coord(sh_x[q]);
                    cy = cell_coord(sh_y[q]);
                    if (!cell_in_grid(cx, cy))
                        expect_word(single_word(ST_OUTSIDE, q));
                    else
                    begin
                        // clamp the 3x3 window at the grid edges
                        i0 = (cx > 0) ? cx - 1 : cx;
                        i1 = (cx + 1 < longint'(sh_rows)) ? cx + 1 : cx;
                        j0 = (cy > 0) ? cy - 1 : cy;
                        j1 = (cy + 1 < longint'(sh_cols)) ? cy + 1 : cy;
                        for (longint i = i0; i <= i1; i++)
                            for (longint j = j0; j <= j1; j++)
                            begin
                                b = bucket_of(i, j);
                                for (int s = 0; s < sh_fill[b]; s++)
                                begin
                                    m = sh_members[b * DEF_BUCKET_DEPTH + s];
                                    if (m == q)
                                        continue;
                                    dx = longint'(sh_x[q]) - longint'(sh_x[m]);
                                    dy = longint'(sh_y[q]) - longint'(sh_y[m]);
                                    d2 = dx * dx + dy * dy;
                                    if (d2 > longint'(sh_range_sq))
                                        continue;
                                    if (hits.size() >= DEF_MAX_NEIGHBORS)
                                    begin
                                        over = 1'b1;
                                        continue;
                                    end
                                    r = '0;
                                    r.status         = ST_OK;
                                    r.particle_index = q[IDX_W-1:0];
                                    r.neighbor_index = m[IDX_W-1:0];
                                    r.neighbor_valid = 1'b1;
                                    hits.insert(hits.size(), r);
                                end
                            end
                        if (hits.size() == 0)
                            expect_word(single_word(ST_OK, q));
                        else
                        begin
                            hits[hits.size() - 1].list_overflow = over;
                            hits[hits.size() - 1].last          = 1'b1;
                            foreach (hits[k]) expect_word(hits[k]);
                        end
                    end
                end
            end
            default:
            begin
                // unused code: no result
            end
        endcase
    endtask

    // Record the word taken at this edge and predict its results.
    always @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_word_t w;
            w.func = func_t'(item.func);
            w.x    = item.pos_x;
            w.y    = item.pos_y;
            w.q    = item.query_index;
            predict_item(w);
            took_item = 1'b1;
        end
    end

    // Driver: offer the next pending word at the falling edge, with idle bursts.
    always @(negedge clk)
    begin
        if (rst_n && (!item.valid || took_item))
        begin
            took_item = 1'b0;
            if (send_idle == 0 && !quiet && $urandom_range(0, 3) == 0)
                send_idle = $urandom_range(1, 5);
            if (send_idle > 0)
            begin
                send_idle--;
                item.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_word_t w;
                w = pending_items.pop_front();
                item.func        <= w.func;
                item.pos_x       <= w.x;
                item.pos_y       <= w.y;
                item.query_index <= w.q;
                item.valid       <= 1'b1;
            end
            else
                item.valid <= 1'b0;
        end
    end

    // Receiver: long hold-off on request, otherwise short random stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold > 0)
            begin
                long_hold--;
                result.ready <= 1'b0;
            end
            else
            begin
                if (recv_stall == 0 && !quiet && $urandom_range(0, 4) == 0)
                    recv_stall = $urandom_range(1, 5);
                if (recv_stall > 0)
                begin
                    recv_stall--;
                    result.ready <= 1'b0;
                end
                else
                    result.ready <= 1'b1;
            end
        end
    end

    // Monitor: check each result word against the oldest expectation.
    always @(posedge clk)
    begin
        if (result.valid && result.ready)
        begin
            result_word_t got;
            result_word_t want;
            got.status         = result.status;
            got.particle_index = result.particle_index;
            got.neighbor_index = result.neighbor_index;
            got.neighbor_valid = result.neighbor_valid;
            got.list_overflow  = result.list_overflow;
            got.last           = result.last;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word st=%0d pidx=%0d nidx=%0d nv=%0b ov=%0b last=%0b",
                             $realtime, got.status, got.particle_index, got.neighbor_index,
                             got.neighbor_valid, got.list_overflow, got.last);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp st=%0d pidx=%0d nidx=%0d nv=%0b ov=%0b last=%0b | got st=%0d pidx=%0d nidx=%0d nv=%0b ov=%0b last=%0b",
                                 $realtime, want.status, want.particle_index, want.neighbor_index,
                                 want.neighbor_valid, want.list_overflow, want.last,
                                 got.status, got.particle_index, got.neighbor_index,
                                 got.neighbor_valid, got.list_overflow, got.last);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (result.valid && result.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("spatial_hash_neighbor_search regression: fail");
                $finish;
            end
        end
    end

    task automatic add_item(input func_t f, input int x, input int y, input int q);
        item_word_t w;
        w.func = f;
        w.x    = x[POS_W-1:0];
        w.y    = y[POS_W-1:0];
        w.q    = q[IDX_W-1:0];
        if (f == FN_CLEAR)
            gen_count = 0;
        else if (f == FN_INSERT && gen_count < DEF_MAX_PARTICLES)
            gen_count++;
        pending_items.insert(pending_items.size(), w);
    endtask

    // Hold until every word is sent and answered, then let the block settle.
    task automatic drain();
        while (pending_items.size() > 0 || item.valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle; mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_CELL_SCALE: sh_scale    = val[SCALE_W-1:0];
            CFG_GRID_ROWS:  sh_rows     = val[CELL_W-1:0];
            CFG_GRID_COLS:  sh_cols     = val[CELL_W-1:0];
            default:        sh_range_sq = val[KRS_W-1:0];
        endcase
    endtask

    task automatic configure(input int scale, input int rows, input int cols,
                             input longint range_sq);
        write_reg(CFG_CELL_SCALE, CFG_DATA_W'(scale));
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_KERNEL, CFG_DATA_W'(range_sq));
    endtask

    // Random phase: mostly clustered inserts and queries of stored particles,
    // plus wild positions, bad indexes, stray clears and unused codes.
    task automatic random_phase(input int base, input int span, input int count);
        int r;
        add_item(FN_CLEAR, $urandom, $urandom, $urandom);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 1)
                add_item(FN_CLEAR, $urandom, $urandom, $urandom);
            else if (r < 4)
                add_item(FN_NOP, $urandom, $urandom, $urandom);
            else if (r < 10)
                add_item(FN_INSERT, $urandom, $urandom, $urandom);
            else if (r < 55)
                add_item(FN_INSERT, base + $urandom_range(0, span),
                         base + $urandom_range(0, span), $urandom);
            else if (r < 62 || gen_count == 0)
                add_item(FN_QUERY, $urandom, $urandom, $urandom_range(0, 1023));
            else
                add_item(FN_QUERY, $urandom, $urandom, $urandom_range(0, gen_count - 1));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        item.valid       = 1'b0;
        item.func        = '0;
        item.pos_x       = '0;
        item.pos_y       = '0;
        item.query_index = '0;
        result.ready     = 1'b0;
        took_item        = 1'b0;
        sh_scale         = RST_CELL_SCALE;
        sh_rows          = RST_GRID_ROWS;
        sh_cols          = RST_GRID_COLS;
        sh_range_sq      = RST_KERNEL;
        sh_count         = 0;
        foreach (sh_fill[k]) sh_fill[k] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings: empty store, extremes, full bucket,
        // grid corner, duplicates, unused code, clear.
        add_item(FN_QUERY, 0, 0, 0);
        add_item(FN_NOP, 0, 0, 0);
        add_item(FN_INSERT, 32'h7FFFFF, 32'h7FFFFF, 1023);
        add_item(FN_INSERT, -8388608, -8388608, 0);
        add_item(FN_INSERT, 0, 0, 0);
        add_item(FN_INSERT, 0, 0, 0);
        add_item(FN_INSERT, 4095, 4096, 0);
        add_item(FN_QUERY, 0, 0, 1023);
        for (int k = 0; k < 9; k++)
            add_item(FN_INSERT, 10 * 4096 + k * 100, 10 * 4096 + k * 50, 0);
        add_item(FN_QUERY, 0, 0, 7);
        add_item(FN_INSERT, 63 * 4096 + 10, 63 * 4096 + 10, 0);
        add_item(FN_INSERT, 62 * 4096 + 4000, 63 * 4096 + 20, 0);
        add_item(FN_QUERY, 0, 0, 16);
        add_item(FN_QUERY, 0, 0, 2);
        add_item(FN_QUERY, 0, 0, 4);
        add_item(FN_CLEAR, 0, 0, 0);
        add_item(FN_QUERY, 0, 0, 0);

        // Dense cluster at reset settings; hold the receiver off so the block
        // fills its output register and stalls the item side.
        random_phase(9 * 4096, 3 * 4096, 90);
        long_hold = 800;
        drain();

        configure(256, 64, 64, 64'd16777216);
        random_phase(9 * 4096, 3 * 4096, 70);
        drain();

        configure(0, 1, 1, 0);
        random_phase(-20000, 40000, 50);
        drain();

        configure(65535, 4096, 4096, 64'hFFFF_FFFF_FFFF);
        random_phase(0, 60000, 50);
        drain();

        configure(128, 1, 4096, 64'd1 << 30);
        random_phase(0, 30000, 50);
        drain();

        configure(512, 4096, 1, 64'd1 << 26);
        random_phase(0, 3000, 50);
        drain();

        // Final part, no idling: back-to-back inserts followed by queries.
        quiet = 1'b1;
        configure(256, 64, 64, 64'd16777216);
        add_item(FN_CLEAR, 0, 0, 0);
        for (int k = 0; k < 16; k++)
            add_item(FN_INSERT, $urandom_range(0, 64 * 4096), $urandom_range(0, 64 * 4096),
                     $urandom);
        add_item(FN_QUERY, 0, 0, 1023);
        add_item(FN_QUERY, 0, 0, 0);
        add_item(FN_QUERY, 0, 0, $urandom_range(0, 15));
        drain();

        mismatches += expected_words.size();
        if (mismatches == 0)
            $display("spatial_hash_neighbor_search regression: pass");
        else
            $display("spatial_hash_neighbor_search regression: fail");
        $finish;
    end

endmodule
